FILE: hw/rtl/pds_pkg.sv
package pds_pkg;

  // Default search limits.
  localparam int FB_LOW_DEF   = 16;
  localparam int FB_HIGH_DEF  = 320;
  localparam int POST_MAX_DEF = 7;

  // Fixed field and register widths.
  localparam int TGT_W  = 31;
  localparam int REF_W  = 26;
  localparam int VLIM_W = 31;
  localparam int AF_W   = 39;
  localparam int FBO_W  = 9;
  localparam int PDO_W  = 3;
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // Register reset values.
  localparam logic [REF_W-1:0]  REF_RST     = REF_W'(12000000);
  localparam logic [VLIM_W-1:0] VCO_MIN_RST = VLIM_W'(750000000);
  localparam logic [VLIM_W-1:0] VCO_MAX_RST = VLIM_W'(1600000000);

  typedef enum logic [1:0] {
    REG_REFERENCE = 2'd0,
    REG_VCO_MIN   = 2'd1,
    REG_VCO_MAX   = 2'd2,
    REG_PREFER    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VCO,
    ST_WIN,
    ST_DIFF,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

FILE: hw/rtl/pll_divider_search.sv
// Channel   | Direction | Ports                                  | Handshake
// ----------+-----------+----------------------------------------+------------------------
// input     | in        | in_target_hz                           | in_valid / in_ready
// result    | out       | out_achieved_freq, out_feedback_div,   | out_valid / out_ready
//           |           | out_post_div_one, out_post_div_two,    |
//           |           | out_found                              |
// config    | in/out    | psel, penable, pwrite, paddr, pwdata,  | APB write, pready = 1
//           |           | prdata, pready                         |
//
// For every feedback value in the scan range the sequencer forms the VCO product and
// checks the window; for each of the POST_MAX*POST_MAX post-divider pairs of every
// feedback value whose VCO lies in the window it forms the difference, the cross
// products and the compare. The final divide then yields one quotient bit per cycle (VCO width + 8).
// Reset is synchronous and active low; it restores the register defaults and idles the
// sequencer. The block takes an item only when the sequencer is idle. A finished result
// sits in the output register until taken; a new item may be accepted meanwhile, and its
// result waits in the last sequencer state until the output register is free.

module pll_divider_search #(
  parameter int FB_LOW   = pds_pkg::FB_LOW_DEF,
  parameter int FB_HIGH  = pds_pkg::FB_HIGH_DEF,
  parameter int POST_MAX = pds_pkg::POST_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pds_pkg::TGT_W-1:0]     in_target_hz,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pds_pkg::AF_W-1:0]      out_achieved_freq,
  output logic [pds_pkg::FBO_W-1:0]     out_feedback_div,
  output logic [pds_pkg::PDO_W-1:0]     out_post_div_one,
  output logic [pds_pkg::PDO_W-1:0]     out_post_div_two,
  output logic                          out_found,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pds_pkg::APB_AW-1:0]    paddr,
  input  logic [pds_pkg::APB_DW-1:0]    pwdata,
  output logic [pds_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  import pds_pkg::*;

  // The feedback counter must hold both scan limits.
  localparam int FB_MAXV  = (FB_LOW > FB_HIGH) ? FB_LOW : FB_HIGH;
  localparam int FB_W     = $clog2(FB_MAXV + 1);
  localparam bit FB_EMPTY = (FB_LOW > FB_HIGH);
  localparam int PD_W     = $clog2(POST_MAX + 1);
  // Product of the two post-dividers.
  localparam int D_W      = 2 * PD_W;
  localparam int VCO_W    = REF_W + FB_W;
  localparam int TD_W     = TGT_W + D_W;
  localparam int DIFF_W   = (VCO_W > TD_W) ? VCO_W : TD_W;
  localparam int WIN_W    = (VCO_W > VLIM_W) ? VCO_W : VLIM_W;
  localparam int PROD_W   = DIFF_W + D_W;
  // Dividend of the final divide is the VCO in 8 fractional bits.
  localparam int DVD_W    = VCO_W + 8;
  localparam int STEP_W   = $clog2(DVD_W);

  localparam logic [FB_W-1:0] FB_FIRST_UP = FB_W'(FB_LOW);
  localparam logic [FB_W-1:0] FB_FIRST_DN = FB_W'(FB_HIGH);
  localparam logic [PD_W-1:0] PD_ONE      = PD_W'(1);
  localparam logic [PD_W-1:0] PD_LAST     = PD_W'(POST_MAX);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

  // Configuration registers.
  logic [REF_W-1:0]  reference_hz_r;
  logic [VLIM_W-1:0] vco_min_hz_r;
  logic [VLIM_W-1:0] vco_max_hz_r;
  logic              prefer_low_vco_r;

  // Sequencer and datapath.
  state_t            state_r,   state_nxt;
  logic [TGT_W-1:0]  target_r,  target_nxt;
  logic [FB_W-1:0]   fb_r,      fb_nxt;
  logic [PD_W-1:0]   p1_r,      p1_nxt;
  logic [PD_W-1:0]   p2_r,      p2_nxt;
  logic [D_W-1:0]    d_r,       d_nxt;
  logic [VCO_W-1:0]  vco_r,     vco_nxt;
  logic [DIFF_W-1:0] diff_r,    diff_nxt;
  logic [PROD_W-1:0] prod_a_r,  prod_a_nxt;
  logic [PROD_W-1:0] prod_b_r,  prod_b_nxt;

  // Best candidate so far; its distance is best_num / best_den.
  logic [DIFF_W-1:0] best_num_r, best_num_nxt;
  logic [D_W-1:0]    best_den_r, best_den_nxt;
  logic [VCO_W-1:0]  best_vco_r, best_vco_nxt;
  logic [FB_W-1:0]   best_fb_r,  best_fb_nxt;
  logic [PD_W-1:0]   best_p1_r,  best_p1_nxt;
  logic [PD_W-1:0]   best_p2_r,  best_p2_nxt;
  logic              hit_r,      hit_nxt;

  // Restoring divider: dq_r shifts the dividend out and the quotient in.
  logic [DVD_W-1:0]  dq_r,   dq_nxt;
  logic [D_W-1:0]    rem_r,  rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [AF_W-1:0]   out_af_r,    out_af_nxt;
  logic [FBO_W-1:0]  out_fb_r,    out_fb_nxt;
  logic [PDO_W-1:0]  out_p1_r,    out_p1_nxt;
  logic [PDO_W-1:0]  out_p2_r,    out_p2_nxt;
  logic              out_found_r, out_found_nxt;

  // Fixed-width views of the results, truncated or zero-extended to the field widths.
  logic [DVD_W+AF_W-1:0]  quot_wide;
  logic [FB_W+FBO_W-1:0]  fb_wide;
  logic [PD_W+PDO_W-1:0]  p1_wide;
  logic [PD_W+PDO_W-1:0]  p2_wide;

  assign quot_wide = {{AF_W{1'b0}}, dq_r};
  assign fb_wide   = {{FBO_W{1'b0}}, best_fb_r};
  assign p1_wide   = {{PDO_W{1'b0}}, best_p1_r};
  assign p2_wide   = {{PDO_W{1'b0}}, best_p2_r};

  // ------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are
  // returned combinationally from the register selected by paddr.
  // ------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reference_hz_r   <= REF_RST;
      vco_min_hz_r     <= VCO_MIN_RST;
      vco_max_hz_r     <= VCO_MAX_RST;
      prefer_low_vco_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_REFERENCE: reference_hz_r   <= pwdata[REF_W-1:0];
        REG_VCO_MIN:   vco_min_hz_r     <= pwdata[VLIM_W-1:0];
        REG_VCO_MAX:   vco_max_hz_r     <= pwdata[VLIM_W-1:0];
        REG_PREFER:    prefer_low_vco_r <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_REFERENCE: prdata = APB_DW'(reference_hz_r);
      REG_VCO_MIN:   prdata = APB_DW'(vco_min_hz_r);
      REG_VCO_MAX:   prdata = APB_DW'(vco_max_hz_r);
      REG_PREFER:    prdata = APB_DW'(prefer_low_vco_r);
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer. Each feedback value first gets its VCO product and then a
  // window check. For an in-window VCO, every post-divider pair runs
  // through three steps: the distance |vco - target*d|, the two cross
  // products against the best distance, and the strict compare. Once the
  // scan ends the divider produces the achieved frequency bit by bit.
  // ------------------------------------------------------------------
  always_comb begin
    logic              next_fb;
    logic              scan_done;
    logic [TD_W-1:0]   td;
    logic [DIFF_W-1:0] vco_ext;
    logic [DIFF_W-1:0] td_ext;
    logic [WIN_W-1:0]  vco_win;
    logic [D_W:0]      trial;
    logic              ge;

    next_fb   = 1'b0;
    scan_done = 1'b0;
    td        = TD_W'(target_r) * TD_W'(d_r);
    vco_ext   = DIFF_W'(vco_r);
    td_ext    = DIFF_W'(td);
    vco_win   = WIN_W'(vco_r);
    trial     = {rem_r, dq_r[DVD_W-1]};
    ge        = (trial >= {1'b0, best_den_r});

    state_nxt     = state_r;
    target_nxt    = target_r;
    fb_nxt        = fb_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    d_nxt         = d_r;
    vco_nxt       = vco_r;
    diff_nxt      = diff_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    best_num_nxt  = best_num_r;
    best_den_nxt  = best_den_r;
    best_vco_nxt  = best_vco_r;
    best_fb_nxt   = best_fb_r;
    best_p1_nxt   = best_p1_r;
    best_p2_nxt   = best_p2_r;
    hit_nxt       = hit_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_af_nxt    = out_af_r;
    out_fb_nxt    = out_fb_r;
    out_p1_nxt    = out_p1_r;
    out_p2_nxt    = out_p2_r;
    out_found_nxt = out_found_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // The starting best distance is the target over one.
          target_nxt   = in_target_hz;
          best_num_nxt = DIFF_W'(in_target_hz);
          best_den_nxt = D_W'(1);
          best_vco_nxt = '0;
          hit_nxt      = 1'b0;
          fb_nxt       = prefer_low_vco_r ? FB_FIRST_UP : FB_FIRST_DN;
          if (FB_EMPTY) begin
            scan_done = 1'b1;
          end else begin
            state_nxt = ST_VCO;
          end
        end
      end
      ST_VCO: begin
        vco_nxt   = VCO_W'(reference_hz_r) * VCO_W'(fb_r);
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        if (vco_win < WIN_W'(vco_min_hz_r) || vco_win > WIN_W'(vco_max_hz_r)) begin
          next_fb = 1'b1;
        end else begin
          p1_nxt    = PD_ONE;
          p2_nxt    = PD_ONE;
          d_nxt     = D_W'(1);
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_nxt  = (vco_ext >= td_ext) ? (vco_ext - td_ext) : (td_ext - vco_ext);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_a_nxt = PROD_W'(diff_r) * PROD_W'(best_den_r);
        prod_b_nxt = PROD_W'(best_num_r) * PROD_W'(d_r);
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        // Only a strictly closer candidate replaces the best one.
        if (prod_a_r < prod_b_r) begin
          best_num_nxt = diff_r;
          best_den_nxt = d_r;
          best_vco_nxt = vco_r;
          best_fb_nxt  = fb_r;
          best_p1_nxt  = p1_r;
          best_p2_nxt  = p2_r;
          hit_nxt      = 1'b1;
        end
        // The first post-divider is the inner loop; d tracks p1*p2 by adding p2.
        if (p1_r == PD_LAST) begin
          if (p2_r == PD_LAST) begin
            next_fb = 1'b1;
          end else begin
            p1_nxt    = PD_ONE;
            p2_nxt    = p2_r + PD_ONE;
            d_nxt     = D_W'(p2_r + PD_ONE);
            state_nxt = ST_DIFF;
          end
        end else begin
          p1_nxt    = p1_r + PD_ONE;
          d_nxt     = d_r + D_W'(p2_r);
          state_nxt = ST_DIFF;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? D_W'(trial - {1'b0, best_den_r}) : trial[D_W-1:0];
        dq_nxt   = {dq_r[DVD_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait here while an earlier result still occupies the output register.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_af_nxt    = hit_r ? quot_wide[AF_W-1:0] : '0;
          out_fb_nxt    = hit_r ? fb_wide[FBO_W-1:0] : '0;
          out_p1_nxt    = hit_r ? p1_wide[PDO_W-1:0] : '0;
          out_p2_nxt    = hit_r ? p2_wide[PDO_W-1:0] : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Step to the next feedback value, or end the scan after the last one.
    if (next_fb) begin
      if (fb_r == (prefer_low_vco_r ? FB_FIRST_DN : FB_FIRST_UP)) begin
        scan_done = 1'b1;
      end else begin
        fb_nxt    = prefer_low_vco_r ? (fb_r + FB_W'(1)) : (fb_r - FB_W'(1));
        state_nxt = ST_VCO;
      end
    end

    if (scan_done) begin
      dq_nxt    = {best_vco_nxt, 8'h00};
      rem_nxt   = '0;
      step_nxt  = '0;
      state_nxt = ST_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    fb_r        <= fb_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    d_r         <= d_nxt;
    vco_r       <= vco_nxt;
    diff_r      <= diff_nxt;
    prod_a_r    <= prod_a_nxt;
    prod_b_r    <= prod_b_nxt;
    best_num_r  <= best_num_nxt;
    best_den_r  <= best_den_nxt;
    best_vco_r  <= best_vco_nxt;
    best_fb_r   <= best_fb_nxt;
    best_p1_r   <= best_p1_nxt;
    best_p2_r   <= best_p2_nxt;
    hit_r       <= hit_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    out_af_r    <= out_af_nxt;
    out_fb_r    <= out_fb_nxt;
    out_p1_r    <= out_p1_nxt;
    out_p2_r    <= out_p2_nxt;
    out_found_r <= out_found_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_achieved_freq = out_af_r;
  assign out_feedback_div  = out_fb_r;
  assign out_post_div_one  = out_p1_r;
  assign out_post_div_two  = out_p2_r;
  assign out_found         = out_found_r;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pds_pkg::*;

  // Highest frequency the stimulus ever asks for, and the top of the VCO limit range.
  localparam longint unsigned FREQ_MAX = 64'd2000000000;

  // One divider choice. The request target rides along only to make reports readable.
  typedef struct packed {
    bit [TGT_W-1:0] target_hz;
    bit [AF_W-1:0]  achieved_freq;
    bit [FBO_W-1:0] feedback_div;
    bit [PDO_W-1:0] post_div_one;
    bit [PDO_W-1:0] post_div_two;
    bit             found;
  } divider_choice_t;

  // Holds a shadow of the search registers, predicts the divider choice for each
  // accepted target and checks the results in order.
  class divider_checker;
    bit [REF_W-1:0]  ref_hz;
    bit [VLIM_W-1:0] vco_lo;
    bit [VLIM_W-1:0] vco_hi;
    bit              ascending;
    divider_choice_t expected_choices[$];
    int              mismatches;

    function new();
      ref_hz     = REF_RST;
      vco_lo     = VCO_MIN_RST;
      vco_hi     = VCO_MAX_RST;
      ascending  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] value);
      case (idx)
        REG_REFERENCE: ref_hz = value[REF_W-1:0];
        REG_VCO_MIN:   vco_lo = value[VLIM_W-1:0];
        REG_VCO_MAX:   vco_hi = value[VLIM_W-1:0];
        REG_PREFER:    ascending = value[0];
        default: ;
      endcase
    endfunction

    // Exhaustive search. A distance is held as best_num / best_den and two distances
    // are compared by cross-multiplication, so no rounding ever enters the choice.
    function divider_choice_t best_dividers(bit [TGT_W-1:0] target);
      divider_choice_t choice;
      bit [63:0] best_num;
      bit [63:0] best_den;
      bit [63:0] best_vco;
      bit [63:0] vco;
      bit [63:0] d;
      bit [63:0] td;
      bit [63:0] diff;
      int        fb;
      choice = '0;
      choice.target_hz = target;
      best_num = 64'(target);
      best_den = 64'd1;
      best_vco = 64'd0;
      for (int k = 0; k <= FB_HIGH_DEF - FB_LOW_DEF; k++) begin
        fb  = ascending ? FB_LOW_DEF + k : FB_HIGH_DEF - k;
        vco = 64'(ref_hz) * 64'(fb);
        if (vco >= 64'(vco_lo) && vco <= 64'(vco_hi)) begin
          for (int p2 = 1; p2 <= POST_MAX_DEF; p2++) begin
            for (int p1 = 1; p1 <= POST_MAX_DEF; p1++) begin
              d    = 64'(p1 * p2);
              td   = 64'(target) * d;
              diff = (vco >= td) ? vco - td : td - vco;
              if (diff * best_den < best_num * d) begin
                best_num            = diff;
                best_den            = d;
                best_vco            = vco;
                choice.feedback_div = FBO_W'(fb);
                choice.post_div_one = PDO_W'(p1);
                choice.post_div_two = PDO_W'(p2);
                choice.found        = 1'b1;
              end
            end
          end
        end
      end
      if (choice.found) begin
        choice.achieved_freq = AF_W'((best_vco << 8) / best_den);
      end
      return choice;
    endfunction

    function void note_request(bit [TGT_W-1:0] target);
      expected_choices.push_back(best_dividers(target));
    endfunction

    function int outstanding();
      return expected_choices.size();
    endfunction

    function void compare_field(string name, bit [63:0] want, bit [63:0] got,
                                bit [TGT_W-1:0] target);
      if (want != got) begin
        $error("%s for target %0d: expected %0d, got %0d", name, target, want, got);
        mismatches++;
      end
    endfunction

    function void check_choice(divider_choice_t got);
      divider_choice_t want;
      if (expected_choices.size() == 0) begin
        $error("Result with no request outstanding: feedback_div %0d, achieved_freq %0d",
               got.feedback_div, got.achieved_freq);
        mismatches++;
        return;
      end
      want = expected_choices.pop_front();
      compare_field("achieved_freq", want.achieved_freq, got.achieved_freq, want.target_hz);
      compare_field("feedback_div", want.feedback_div, got.feedback_div, want.target_hz);
      compare_field("post_div_one", want.post_div_one, got.post_div_one, want.target_hz);
      compare_field("post_div_two", want.post_div_two, got.post_div_two, want.target_hz);
      compare_field("found", want.found, got.found, want.target_hz);
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TGT_W-1:0]   in_target_hz = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [AF_W-1:0]    out_achieved_freq;
  logic [FBO_W-1:0]   out_feedback_div;
  logic [PDO_W-1:0]   out_post_div_one;
  logic [PDO_W-1:0]   out_post_div_two;
  logic               out_found;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  divider_checker board = new();

  // Idle percentages of the two sides; the stimulus process changes them per phase.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // A nonzero value asks the receiver for one long hold-off of that many cycles.
  int hold_request = 0;
  int hold_left = 0;

  // The current random window: reference, lowest in-window feedback value and span.
  longint unsigned win_ref;
  int              win_fb;
  int              win_span;

  pll_divider_search uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_target_hz      (in_target_hz),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_achieved_freq (out_achieved_freq),
    .out_feedback_div  (out_feedback_div),
    .out_post_div_one  (out_post_div_one),
    .out_post_div_two  (out_post_div_two),
    .out_found         (out_found),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every task below is entered and left right after a rising edge, and every input is
  // changed by a nonblocking assignment there. Handshakes are judged from the values
  // that held just before the edge, so the order of processes within a step is harmless.

  // APB write: setup cycle, then access cycle; the register takes the value at the edge
  // where psel, penable and pready are high. The task then waits for a further edge with psel
  // low, so that two writes in a row never assign psel twice in the same step.
  task automatic cfg_write(reg_idx_t idx, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_window(longint unsigned reference, longint unsigned lo,
                            longint unsigned hi, bit prefer_low);
    cfg_write(REG_REFERENCE, 32'(reference));
    cfg_write(REG_VCO_MIN, 32'(lo));
    cfg_write(REG_VCO_MAX, 32'(hi));
    cfg_write(REG_PREFER, 32'(prefer_low));
  endtask

  // Offers one target and returns in the step where it was accepted. The valid stays
  // high afterwards, so back-to-back items never drop it; a random gap lowers it first.
  task automatic send_item(bit [TGT_W-1:0] target);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_target_hz <= target;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_request(target);
  endtask

  // Called in the step of the last acceptance of a burst.
  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // A window that holds between one and nine feedback values keeps each search short.
  // One window in five uses a tiny reference so that the VCO values are tiny as well.
  task automatic random_window();
    longint unsigned lo;
    longint unsigned hi;
    int              fb_top;
    if ($urandom_range(0, 4) == 0) begin
      win_ref = $urandom_range(1, 5000);
    end else begin
      win_ref = $urandom_range(1000000, 50000000);
    end
    if (FREQ_MAX / win_ref > FB_HIGH_DEF) begin
      fb_top = FB_HIGH_DEF - 8;
    end else begin
      fb_top = int'(FREQ_MAX / win_ref) - 8;
    end
    win_fb   = $urandom_range(FB_LOW_DEF, fb_top);
    win_span = $urandom_range(0, 8);
    // The slack stays below one reference step, so no neighbor slips into the window.
    lo = win_ref * win_fb - $urandom_range(0, 32'(win_ref - 1));
    hi = win_ref * (win_fb + win_span) + $urandom_range(0, 32'(win_ref - 1));
    if (hi > FREQ_MAX) hi = FREQ_MAX;
    set_window(win_ref, lo, hi, 1'($urandom_range(0, 1)));
  endtask

  // Mostly targets close to what the window can reach, some of them exact so that
  // several divider sets tie; the rest are spread over the whole range or tiny.
  function automatic bit [TGT_W-1:0] pick_target();
    longint          t;
    longint unsigned vco;
    int              d;
    int              sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      t = $urandom_range(0, 32'(FREQ_MAX));
    end else if (sel == 1) begin
      t = $urandom_range(0, 1000);
    end else begin
      vco = win_ref * (win_fb + $urandom_range(0, win_span));
      d   = $urandom_range(1, POST_MAX_DEF) * $urandom_range(1, POST_MAX_DEF);
      t   = longint'(vco / d);
      if (sel > 4) t = t + int'($urandom_range(0, 200)) - 100;
    end
    if (t < 0) t = 0;
    if (t > longint'(FREQ_MAX)) t = longint'(FREQ_MAX);
    return TGT_W'(t);
  endfunction

  // Receiver: checks each accepted result, then decides out_ready for the next cycle.
  // A long hold-off is counted down here, independent of the stimulus process.
  initial begin
    divider_choice_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        got               = '0;
        got.achieved_freq = out_achieved_freq;
        got.feedback_div  = out_feedback_div;
        got.post_div_one  = out_post_div_one;
        got.post_div_two  = out_post_div_two;
        got.found         = out_found;
        board.check_choice(got);
      end
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: 12 MHz reference, 750 to 1600 MHz window, descending scan.
    // A zero target can never be beaten, the largest target is far above any output,
    // and 100 MHz is reached exactly by several feedback values, so the scan order
    // decides the tie.
    send_item(31'd0);
    send_item(31'(FREQ_MAX));
    send_item(31'd100000000);
    send_item(31'd1);
    release_input();
    wait_drained();

    // Same window scanned upward: the tie now goes to the lowest feedback value.
    cfg_write(REG_PREFER, 32'd1);
    send_item(31'd100000000);
    send_item(31'd48000000);
    release_input();
    wait_drained();

    // Largest reference with the widest window: feedback values 16 to 40 qualify.
    set_window(50000000, 0, FREQ_MAX, 1'b1);
    send_item(31'(FREQ_MAX));
    send_item(31'd0);
    send_item(31'd7142857);
    send_item(31'd1234567);
    release_input();
    wait_drained();

    // Smallest reference: VCO values of 16 to 20 Hz.
    set_window(1, 0, 20, 1'b0);
    send_item(31'd3);
    send_item(31'd20);
    send_item(31'(FREQ_MAX));
    release_input();
    wait_drained();

    // Zero reference with a window that holds only zero: every feedback value passes
    // the window check, yet no candidate is ever closer than the target itself.
    set_window(0, 0, 0, 1'b0);
    send_item(31'd1000);
    release_input();
    wait_drained();

    // Inverted window skips every feedback value.
    set_window(12000000, FREQ_MAX, 0, 1'b1);
    send_item(31'd100000000);
    release_input();
    wait_drained();

    // Random part in three idling modes, four windows each. In the last mode the
    // receiver holds off long enough for the block to fill up and stall its input.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int w = 0; w < 4; w++) begin
        random_window();
        if (mode == 2 && w == 0) hold_request = 10000;
        repeat (7) send_item(pick_target());
        release_input();
        // The sender pauses here until every result of the burst has come back.
        wait_drained();
      end
    end

    // Give a stray extra result time to show up before the verdict.
    repeat (3000) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // A correct run ends long before this watchdog fires.
  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: pll_divider_search.f
hw/rtl/pds_pkg.sv
hw/rtl/pll_divider_search.sv
verif/testbench.sv
